### rtl/mh64_pkg.sv
// ----------------------------------------------------------------------------
// mh64_pkg
// constants and helpers shared by the murmurhash64a engine modules
// ----------------------------------------------------------------------------
package mh64_pkg;

  localparam logic [63:0] MH_MUL     = 64'hc6a4a7935bd1e995;
  localparam logic [63:0] MH_SEED    = 64'h8445d61a4e774912;
  localparam int unsigned MH_SHIFT   = 47;
  localparam logic [3:0]  FULL_BYTES = 4'd8;

  localparam logic [31:0] MUL_LO = MH_MUL[31:0];
  localparam logic [31:0] MUL_HI = MH_MUL[63:32];

  // keep only the bytes below nbytes
  function automatic logic [63:0] tail_mask(input logic [3:0] nbytes);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nbytes) begin
        m[i*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

  // x ^ (x >> 47)
  function automatic logic [63:0] xor_shift(input logic [63:0] x);
    return x ^ (x >> MH_SHIFT);
  endfunction

endpackage

### rtl/mh64_mul.sv
// ----------------------------------------------------------------------------
// mh64_mul
// iterative 64-bit multiply by the mixing constant, modulo 2^64, on one
// 32x32 multiplier: the low product first, then the two cross products
// ----------------------------------------------------------------------------
module mh64_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] operand,
  output logic        done,
  output logic [63:0] product
);

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_CROSS1,
    MUL_CROSS2
  } mul_state_t;

  mul_state_t  state_r;
  logic [63:0] a_r;
  logic [63:0] acc_r;
  logic        done_r;

  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] mul_p;

  // operand select for the shared multiplier
  always_comb begin
    case (state_r)
      MUL_IDLE: begin
        mul_x = operand[31:0];
        mul_y = mh64_pkg::MUL_LO;
      end
      MUL_CROSS1: begin
        mul_x = a_r[31:0];
        mul_y = mh64_pkg::MUL_HI;
      end
      MUL_CROSS2: begin
        mul_x = a_r[63:32];
        mul_y = mh64_pkg::MUL_LO;
      end
      default: begin
        mul_x = operand[31:0];
        mul_y = mh64_pkg::MUL_LO;
      end
    endcase
  end

  assign mul_p = 64'(mul_x) * 64'(mul_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MUL_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        MUL_IDLE: begin
          if (start) begin
            a_r     <= operand;
            acc_r   <= mul_p;
            state_r <= MUL_CROSS1;
          end
        end
        MUL_CROSS1: begin
          acc_r[63:32] <= acc_r[63:32] + mul_p[31:0];
          state_r      <= MUL_CROSS2;
        end
        MUL_CROSS2: begin
          acc_r[63:32] <= acc_r[63:32] + mul_p[31:0];
          done_r       <= 1'b1;
          state_r      <= MUL_IDLE;
        end
        default: begin
          state_r <= MUL_IDLE;
        end
      endcase
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

### rtl/murmurhash64a_engine_top.sv
// ----------------------------------------------------------------------------
// murmurhash64a_engine_top
// streaming murmurhash64a: mixes 8-byte key chunks into a running hash and
// emits the finalized 64-bit hash when a key ends
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  in_      | input     | in_valid / in_ready  | chunk_word, chunk_bytes,
//           |           |                      | first_chunk, last_chunk,
//           |           |                      | key_length
//  out_     | output    | out_valid/out_ready  | hash_value
//
//  every multiply by the mixing constant runs through one shared 32x32
//  multiplier, one after another, so a chunk works as follows:
//    full chunk k*m, (k ^ k>>47)*m, then h*m; tail chunk h*m only; a
//    first chunk adds len*m ahead, and a key end adds the finalize multiply
//    and the hand-off, held while an earlier hash waits in the output register
//  in_ready is high only while the sequencer is idle; the result sits in an
//  output register, so the next item is taken while it waits
//  rst_n (synchronous) clears the sequencer, the running hash and out_valid
// ----------------------------------------------------------------------------
module murmurhash64a_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  // input item
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_chunk_word,
  input  logic [3:0]  in_chunk_bytes,
  input  logic        in_first_chunk,
  input  logic        in_last_chunk,
  input  logic [31:0] in_key_length,
  // result item
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash_value
);

  typedef enum logic [2:0] {
    S_IDLE,  // waiting for an item
    S_SEED,  // key_length * m in flight
    S_MIX,   // pick full, tail or empty path
    S_K1,    // k * m in flight
    S_K2,    // (k ^ k>>47) * m in flight
    S_H,     // h * m in flight
    S_FIN,   // finalize multiply in flight
    S_OUT    // finalized hash waits for the output register
  } state_t;

  state_t      state_r, state_nxt;

  // latched item
  logic [63:0] word_r;
  logic [3:0]  nb_r;
  logic        ends_r;

  // running hash and finalized result
  logic [63:0] hash_r, hash_nxt;
  logic [63:0] res_r, res_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;

  // shared multiplier hookup
  logic        mul_start;
  logic [63:0] mul_a;
  logic        mul_done;
  logic [63:0] mul_p;

  logic        in_acc;
  logic [3:0]  nb_clamped;

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  // counts above eight act as a full chunk
  assign nb_clamped = (in_chunk_bytes > mh64_pkg::FULL_BYTES) ? mh64_pkg::FULL_BYTES
                                                              : in_chunk_bytes;

  mh64_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .operand (mul_a),
    .done    (mul_done),
    .product (mul_p)
  );

  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_hash_nxt  = out_hash_r;
    mul_start     = 1'b0;
    mul_a         = hash_r;

    // result leaves the output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_first_chunk) begin
            // seed path: h = seed ^ (len * m)
            mul_start = 1'b1;
            mul_a     = {32'd0, in_key_length};
            state_nxt = S_SEED;
          end else begin
            state_nxt = S_MIX;
          end
        end
      end
      S_SEED: begin
        if (mul_done) begin
          hash_nxt  = mh64_pkg::MH_SEED ^ mul_p;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        if (nb_r == mh64_pkg::FULL_BYTES) begin
          mul_start = 1'b1;
          mul_a     = word_r;
          state_nxt = S_K1;
        end else if (nb_r != 4'd0) begin
          // tail bytes fold straight into h
          hash_nxt  = hash_r ^ (word_r & mh64_pkg::tail_mask(nb_r));
          mul_start = 1'b1;
          mul_a     = hash_nxt;
          state_nxt = S_H;
        end else begin
          // empty chunk: no mixing, go finalize
          mul_start = 1'b1;
          mul_a     = mh64_pkg::xor_shift(hash_r);
          state_nxt = S_FIN;
        end
      end
      S_K1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mh64_pkg::xor_shift(mul_p);
          state_nxt = S_K2;
        end
      end
      S_K2: begin
        if (mul_done) begin
          hash_nxt  = hash_r ^ mul_p;
          mul_start = 1'b1;
          mul_a     = hash_nxt;
          state_nxt = S_H;
        end
      end
      S_H: begin
        if (mul_done) begin
          hash_nxt = mul_p;
          if (ends_r) begin
            // finalize works on a copy, the running hash keeps mul_p
            mul_start = 1'b1;
            mul_a     = mh64_pkg::xor_shift(mul_p);
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FIN: begin
        if (mul_done) begin
          res_nxt   = mh64_pkg::xor_shift(mul_p);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hash_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_hash_r <= out_hash_nxt;
    if (in_acc) begin
      word_r <= in_chunk_word;
      nb_r   <= nb_clamped;
      // a short chunk always closes the key
      ends_r <= in_last_chunk || (nb_clamped < mh64_pkg::FULL_BYTES);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

### verif/tb_murmurhash64a_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_murmurhash64a_engine_top
// self-checking bench for the streaming murmurhash64a engine
//
// Chunks go in through a valid/ready handshake, and the bench keeps its own
// running hash of them. Every chunk that ends a key pushes the hash it
// should give onto a queue, and each hash the block hands out is checked
// against the oldest entry. A short directed table comes first. Its rows
// that start from a zero hash carry their hash typed in. Then come random
// keys, most of them well formed, with some broken keys and loose chunks.
// Both sides idle under two profiles and not at all under a third, and
// once the output holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_murmurhash64a_engine_top;

  localparam int unsigned CYCLE_LIMIT   = 600000; // generous run limit
  localparam int unsigned SETTLE_CYCLES = 40;     // quiet time after a drain
  localparam int unsigned HOLD_CYCLES   = 300;    // long output hold-off
  localparam int unsigned PHASE_ITEMS   = 600;    // items per idle profile

  // one input item, with an optional typed-in hash for the directed rows
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        is_first;
    logic        is_last;
    logic [31:0] klen;
    logic        typed;
    logic [63:0] typed_hash;
  } chunk_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_chunk_word;
  logic [3:0]  in_chunk_bytes;
  logic        in_first_chunk;
  logic        in_last_chunk;
  logic [31:0] in_key_length;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_hash_value;

  // bench copy of the running hash, and the hashes still to come out
  logic [63:0] run_hash;
  logic [63:0] pending_hashes [$];
  logic [63:0] want_hash;

  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned items_sent;
  int unsigned hashes_seen;
  int unsigned keys_sent;
  int unsigned loose_sent;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  bit          hold_out_req;

  chunk_t dir_tab [0:19];

  murmurhash64a_engine_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_chunk_word  (in_chunk_word),
    .in_chunk_bytes (in_chunk_bytes),
    .in_first_chunk (in_first_chunk),
    .in_last_chunk  (in_last_chunk),
    .in_key_length  (in_key_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit: a hang ends the run as a failure
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d hashes pending", $time, cycle_cnt,
               pending_hashes.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // advance the bench hash by one chunk; a key end yields the finalized hash
  task automatic absorb_chunk(input chunk_t c, output bit ends, output logic [63:0] digest);
    logic [63:0] h;
    logic [63:0] k;
    logic [63:0] keep;
    logic [3:0]  n;
    h = run_hash;
    n = (c.nbytes > mh64_pkg::FULL_BYTES) ? mh64_pkg::FULL_BYTES : c.nbytes;
    if (c.is_first) begin
      h = mh64_pkg::MH_SEED ^ ({32'd0, c.klen} * mh64_pkg::MH_MUL);
    end
    if (n == mh64_pkg::FULL_BYTES) begin
      k = c.word * mh64_pkg::MH_MUL;
      k = k ^ (k >> mh64_pkg::MH_SHIFT);
      k = k * mh64_pkg::MH_MUL;
      h = (h ^ k) * mh64_pkg::MH_MUL;
    end else if (n != 4'd0) begin
      // tail chunk: bytes at or above the count are dropped
      keep = ~(64'hffff_ffff_ffff_ffff << (8 * n));
      h = (h ^ (c.word & keep)) * mh64_pkg::MH_MUL;
    end
    run_hash = h;
    ends = c.is_last || (n < mh64_pkg::FULL_BYTES);
    // finalize on a copy, the running hash stays unfinalized
    h = h ^ (h >> mh64_pkg::MH_SHIFT);
    h = h * mh64_pkg::MH_MUL;
    digest = h ^ (h >> mh64_pkg::MH_SHIFT);
  endtask

  // offer one item, hold it until taken, then maybe idle for a while
  task automatic send_chunk(input chunk_t c);
    bit          ends;
    logic [63:0] digest;
    in_valid       <= 1'b1;
    in_chunk_word  <= c.word;
    in_chunk_bytes <= c.nbytes;
    in_first_chunk <= c.is_first;
    in_last_chunk  <= c.is_last;
    in_key_length  <= c.klen;
    do @(posedge clk); while (!in_ready);
    absorb_chunk(c, ends, digest);
    if (ends) begin
      pending_hashes = {pending_hashes, (c.typed ? c.typed_hash : digest)};
    end
    items_sent++;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // sender pauses until every pending hash is out and the block is quiet
  task automatic drain_hashes();
    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one key cut into chunks with random content; sometimes a wrong length
  // or a dropped final chunk
  task automatic send_random_key();
    int unsigned len;
    int unsigned nchunks;
    int unsigned sel;
    bit          cut;
    chunk_t      c;
    sel = $urandom_range(99);
    if (sel < 6) begin
      len = 0;
    end else if (sel < 88) begin
      len = $urandom_range(40, 1);
    end else begin
      len = $urandom_range(160, 41);
    end
    nchunks = (len + 7) / 8;
    cut = ($urandom_range(19) == 0) && (nchunks > 1);
    c = '0;
    c.klen = ($urandom_range(9) == 0) ? 32'($urandom) : 32'(len);
    if (len == 0) begin
      // empty key: no mixing, only the seed and the length field go in
      c.word     = {$urandom, $urandom};
      c.is_first = 1'b1;
      c.is_last  = 1'b1;
      send_chunk(c);
    end else begin
      for (int unsigned i = 0; i < nchunks; i++) begin
        if (cut && (i == nchunks - 1)) break;
        c.word     = {$urandom, $urandom};
        c.is_first = (i == 0);
        if (8 * (i + 1) <= len) begin
          // full chunk; an oversized count acts as eight
          c.nbytes  = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 9))
                                                : mh64_pkg::FULL_BYTES;
          c.is_last = (i == nchunks - 1);
        end else begin
          // tail chunk ends the key whether or not it is marked last
          c.nbytes  = 4'(len % 8);
          c.is_last = 1'($urandom_range(1));
        end
        send_chunk(c);
      end
    end
    keys_sent++;
  endtask

  // a loose chunk with every field random
  task automatic send_loose_chunk();
    chunk_t c;
    c          = '0;
    c.word     = {$urandom, $urandom};
    c.nbytes   = 4'($urandom_range(15));
    c.is_first = 1'($urandom_range(1));
    c.is_last  = 1'($urandom_range(1));
    c.klen     = 32'($urandom);
    send_chunk(c);
    loose_sent++;
  endtask

  task automatic run_random_phase(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 12) begin
        send_loose_chunk();
      end else begin
        send_random_key();
      end
    end
  endtask

  // receiver: random stalls, and a long hold-off when asked
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out_req) begin
        out_ready <= 1'b0;
        for (int unsigned hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) begin
          @(posedge clk);
        end
        hold_out_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // result checker: each hash against the oldest pending one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      hashes_seen <= hashes_seen + 1;
      if (pending_hashes.size() == 0) begin
        err_cnt = err_cnt + 1;
        $display("%0t: unexpected hash, expected none, actual %h", $time, out_hash_value);
      end else begin
        want_hash = pending_hashes.pop_front();
        if (out_hash_value !== want_hash) begin
          err_cnt = err_cnt + 1;
          $display("%0t: hash_value mismatch, expected %h, actual %h", $time, want_hash,
                   out_hash_value);
        end
      end
    end
  end

  initial begin
    // all inputs known from time zero, with reset asserted
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_chunk_word  <= '0;
    in_chunk_bytes <= '0;
    in_first_chunk <= 1'b0;
    in_last_chunk  <= 1'b0;
    in_key_length  <= '0;
    run_hash     = '0;
    err_cnt      = 0;
    items_sent   = 0;
    hashes_seen  = 0;
    keys_sent    = 0;
    loose_sent   = 0;
    hold_out_req = 1'b0;
    snd_idle_pct = 29;
    rcv_idle_pct = 71;

    // directed table: word, bytes, first, last, length, typed, typed hash
    // the first rows run from the zero hash after reset, so they hash to zero
    dir_tab = '{
      // empty chunk without a first mark right after reset
      '{64'hffff_ffff_ffff_ffff, 4'd0,  1'b0, 1'b1, 32'hffff_ffff, 1'b1, 64'h0},
      // stray bits above a 3-byte tail are masked off, short chunk ends key
      '{64'hffff_ffff_ff00_0000, 4'd3,  1'b0, 1'b0, 32'h0,         1'b1, 64'h0},
      // zero full chunk keeps a zero hash
      '{64'h0,                   4'd8,  1'b0, 1'b1, 32'h0,         1'b1, 64'h0},
      // oversized counts act as full chunks
      '{64'h0,                   4'd15, 1'b0, 1'b0, 32'h0,         1'b0, 64'h0},
      '{64'h0,                   4'd9,  1'b0, 1'b1, 32'hffff_ffff, 1'b1, 64'h0},
      // empty key proper
      '{64'h0,                   4'd0,  1'b1, 1'b1, 32'h0,         1'b0, 64'h0},
      '{64'hffff_ffff_ffff_ffff, 4'd8,  1'b1, 1'b1, 32'd8,         1'b0, 64'h0},
      // three-chunk key with a 7-byte tail, maximum length field
      '{64'h0123_4567_89ab_cdef, 4'd8,  1'b1, 1'b0, 32'hffff_ffff, 1'b0, 64'h0},
      '{64'hffff_ffff_ffff_ffff, 4'd8,  1'b0, 1'b0, 32'h0,         1'b0, 64'h0},
      '{64'hffff_ffff_ffff_ffff, 4'd7,  1'b0, 1'b1, 32'h0,         1'b0, 64'h0},
      '{64'h0000_0000_0000_00ff, 4'd1,  1'b1, 1'b1, 32'd1,         1'b0, 64'h0},
      // short first chunk ends the key without a last mark
      '{64'hdead_beef_cafe_f00d, 4'd5,  1'b1, 1'b0, 32'd5,         1'b0, 64'h0},
      // no first mark after a key end: continues the stored hash
      '{64'h8000_0000_0000_0000, 4'd8,  1'b0, 1'b1, 32'h0,         1'b0, 64'h0},
      // length field disagrees with the chunks
      '{64'h1111_2222_3333_4444, 4'd8,  1'b1, 1'b0, 32'd3,         1'b0, 64'h0},
      '{64'h5555_6666_7777_8888, 4'd2,  1'b0, 1'b1, 32'h0,         1'b0, 64'h0},
      '{64'haaaa_aaaa_5555_5555, 4'd4,  1'b1, 1'b1, 32'd4,         1'b0, 64'h0},
      '{64'hfedc_ba98_7654_3210, 4'd12, 1'b1, 1'b0, 32'd16,        1'b0, 64'h0},
      '{64'h0f0f_0f0f_0f0f_0f0f, 4'd6,  1'b0, 1'b0, 32'h0,         1'b0, 64'h0},
      '{64'h5555_5555_5555_5555, 4'd8,  1'b1, 1'b1, 32'h8000_0000, 1'b0, 64'h0},
      '{64'h00ff_00ff_00ff_00ff, 4'd6,  1'b1, 1'b1, 32'd6,         1'b0, 64'h0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows under the first idle profile
    foreach (dir_tab[i]) begin
      send_chunk(dir_tab[i]);
    end
    drain_hashes();

    // profile one: sender idles 29 percent, receiver 71
    run_random_phase(PHASE_ITEMS);
    drain_hashes();

    // profile two: the other way round
    snd_idle_pct = 71;
    rcv_idle_pct = 29;
    run_random_phase(PHASE_ITEMS);
    drain_hashes();

    // profile three: no idling, opened by a long output hold-off while
    // the sender keeps offering, so the block backs up and stalls its input
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_out_req = 1'b1;
    run_random_phase(PHASE_ITEMS);
    drain_hashes();

    $display("covered %0d items: %0d random keys, %0d loose chunks, %0d hashes checked",
             items_sent, keys_sent, loose_sent, hashes_seen);
    $display("idle profiles 29/71, 71/29 and none, plus a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
rtl/mh64_pkg.sv
rtl/mh64_mul.sv
rtl/murmurhash64a_engine_top.sv
verif/tb_murmurhash64a_engine_top.sv
